// File: hw/rtl/integer_set_table_macros.svh
// ---------------------------------------------------------------------------
// integer_set_table assertion macros
// Concurrent assertion shorthands, all clocked on clk.
// ---------------------------------------------------------------------------
`ifndef INTEGER_SET_TABLE_MACROS_SVH
`define INTEGER_SET_TABLE_MACROS_SVH

// property checked only outside reset
`define IST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define IST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/ist_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_pkg
// Shared constants, codes and types of the integer set table.
// ---------------------------------------------------------------------------
package ist_pkg;

  // table geometry
  localparam int CAPACITY      = 16;
  localparam int INITIAL_SLOTS = 10;
  localparam int USED_W        = $clog2(CAPACITY + 1);

  // field widths
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef logic [OPCODE_W-1:0]       opcode_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [STATUS_W-1:0]       status_t;
  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic [USED_W-1:0]         used_t;

  // operation codes (the unused code behaves as a lookup)
  localparam opcode_t OP_LOOKUP = 2'd0;
  localparam opcode_t OP_INSERT = 2'd1;
  localparam opcode_t OP_REMOVE = 2'd2;

  // result status codes
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_NOCHANGE = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic   shift_en;  // drop the first matching entry, pull the rest down
    logic   ins_en;    // write key into the first zero slot
    value_t key;
  } cell_cmd_t;

  // summary of the cell row back to the controller
  typedef struct packed {
    logic any_match;  // key is held by a slot in use
    logic any_zero;   // some slot holds zero
    logic claim_new;  // the claimed zero slot was not in use yet
  } cell_sum_t;

endpackage

// File: hw/rtl/ist_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist channel interfaces
// Valid/ready channels for operations in and results out.
// ---------------------------------------------------------------------------
interface ist_in_if;
  import ist_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  value_t  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface ist_out_if;
  import ist_pkg::*;

  logic    valid;
  logic    ready;
  logic    member;
  status_t status;
  count_t  count;

  modport source (output valid, output member, output status, output count, input ready);
  modport sink   (input valid, input member, input status, input count, output ready);
endinterface

// File: hw/rtl/ist_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_cell
// One slot of the table: value, in-use flag, compare and neighbor shift.
// ---------------------------------------------------------------------------
module ist_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rst_inuse,
  input  ist_pkg::cell_cmd_t cmd,
  input  logic               kill_in,
  input  logic               zero_in,
  input  ist_pkg::value_t    nb_value,
  input  logic               nb_inuse,
  output logic               kill_out,
  output logic               zero_out,
  output ist_pkg::value_t    value_out,
  output logic               inuse_out,
  output logic               claim_new
);
  import ist_pkg::*;

  value_t value_r, value_nxt;
  logic   inuse_r, inuse_nxt;
  logic   match;
  logic   is_zero;
  logic   claim;

  // compare against the key and extend the chains to the right
  assign match    = inuse_r && (value_r == cmd.key);
  assign is_zero  = (value_r == '0);
  assign kill_out = kill_in | match;
  assign zero_out = zero_in | is_zero;
  assign claim    = is_zero && !zero_in;
  assign claim_new = claim && !inuse_r;

  assign value_out = value_r;
  assign inuse_out = inuse_r;

  // pull from the upper neighbor at and above the first match, or take the key
  always_comb begin
    value_nxt = value_r;
    inuse_nxt = inuse_r;
    if (cmd.shift_en && kill_out) begin
      value_nxt = nb_value;
      inuse_nxt = nb_inuse;
    end else if (cmd.ins_en && claim) begin
      value_nxt = cmd.key;
      inuse_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      inuse_r <= rst_inuse;
    end else begin
      value_r <= value_nxt;
      inuse_r <= inuse_nxt;
    end
  end

endmodule

// File: hw/rtl/ist_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_ctrl
// Sequencer: takes operations, drives the cell row, keeps the slot count.
// ---------------------------------------------------------------------------
module ist_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  ist_in_if.sink             in_ch,
  ist_out_if.source          out_ch,
  input  ist_pkg::cell_sum_t sum,
  output ist_pkg::cell_cmd_t cmd
);
  import ist_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic    state_r, state_nxt;
  logic    first_r, first_nxt;
  opcode_t op_r;
  value_t  key_r;
  used_t   used_r, used_nxt;

  logic    out_valid_r, out_valid_nxt;
  logic    out_member_r;
  status_t out_status_r;
  count_t  out_count_r;

  logic    out_free;
  logic    finish;
  logic    member;
  status_t status;
  logic    in_acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // member holds before the first removal step only; after it the key was present
  assign member = sum.any_match || !first_r;

  // per-operation sequencing
  always_comb begin
    state_nxt    = state_r;
    first_nxt    = first_r;
    used_nxt     = used_r;
    finish       = 1'b0;
    status       = ST_DONE;
    cmd.shift_en = 1'b0;
    cmd.ins_en   = 1'b0;
    cmd.key      = key_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
          first_nxt = 1'b1;
        end
      end
      S_EXEC: begin
        if (op_r == OP_REMOVE && sum.any_match) begin
          // drop one matching entry per cycle
          cmd.shift_en = 1'b1;
          first_nxt    = 1'b0;
          used_nxt     = used_r - used_t'(1);
        end else begin
          finish = out_free;
          priority if (op_r == OP_INSERT) begin
            if (sum.any_match) begin
              status = ST_NOCHANGE;
            end else if (sum.any_zero) begin
              status     = ST_DONE;
              cmd.ins_en = out_free;
              if (out_free && sum.claim_new) begin
                used_nxt = used_r + used_t'(1);
              end
            end else begin
              status = ST_FULL;
            end
          end else if (op_r == OP_REMOVE) begin
            status = first_r ? ST_NOCHANGE : ST_DONE;
          end else begin
            status = ST_DONE;
          end
          if (finish) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b1;
      used_r      <= used_t'((INITIAL_SLOTS > CAPACITY) ? CAPACITY : INITIAL_SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_ch.opcode;
      key_r <= in_ch.value;
    end
    if (finish) begin
      out_member_r <= member;
      out_status_r <= status;
      out_count_r  <= count_t'(used_nxt);
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.member = out_member_r;
  assign out_ch.status = out_status_r;
  assign out_ch.count  = out_count_r;

endmodule

// File: hw/rtl/integer_set_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_set_table
// Bounded set of signed 32-bit values held in a row of slot cells.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one operation per transaction: opcode (lookup, insert,
//   remove; the spare code acts as a lookup) and a signed value. out_ch
//   returns one result per operation: membership before the operation, a
//   status (done, no change, full) and the number of slots in use after it.
//   Each result is registered in the output register. A remove drops every
//   equal entry it finds before it completes, since the slot row pulls
//   down by one position per cycle. One operation runs at a time;
//   in_ch.ready is high whenever no operation is in flight.
//   Reset (rst_n low, synchronous) leaves ten slots in use, all holding zero.
//   The result sits in an output register; while it waits on out_ch.ready
//   the next operation is taken and runs, and it completes as soon as the
//   output register is free.
// ---------------------------------------------------------------------------
module integer_set_table (
  input  logic       clk,
  input  logic       rst_n,
  ist_in_if.sink     in_ch,
  ist_out_if.source  out_ch
);
  import ist_pkg::*;

  cell_cmd_t            cmd;
  cell_sum_t            sum;
  logic [CAPACITY:0]    kill;
  logic [CAPACITY:0]    zero;
  value_t               vals [CAPACITY+1];
  logic [CAPACITY:0]    inuse;
  logic [CAPACITY-1:0]  claim_new;

  // chain ends: nothing seen on the left, empty slot beyond the top
  assign kill[0]        = 1'b0;
  assign zero[0]        = 1'b0;
  assign vals[CAPACITY] = '0;
  assign inuse[CAPACITY] = 1'b0;

  ist_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .sum    (sum),
    .cmd    (cmd)
  );

  // slot row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ist_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .rst_inuse (i < INITIAL_SLOTS),
      .cmd       (cmd),
      .kill_in   (kill[i]),
      .zero_in   (zero[i]),
      .nb_value  (vals[i+1]),
      .nb_inuse  (inuse[i+1]),
      .kill_out  (kill[i+1]),
      .zero_out  (zero[i+1]),
      .value_out (vals[i]),
      .inuse_out (inuse[i]),
      .claim_new (claim_new[i])
    );
  end

  // row summary for the sequencer
  assign sum.any_match = kill[CAPACITY];
  assign sum.any_zero  = zero[CAPACITY];
  assign sum.claim_new = |claim_new;

endmodule

// File: hw/rtl/ist_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ist_checker
// Port-level checks of the integer set table, bound to the top level.
// ---------------------------------------------------------------------------
`include "integer_set_table_macros.svh"

module ist_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_member,
  input ist_pkg::status_t out_status,
  input ist_pkg::count_t  out_count
);
  import ist_pkg::*;

  // a result stays offered until it is taken
  `IST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // no result comes out of reset
  `IST_ASSERT_ALWAYS(a_rst_quiet, $past(!rst_n) |-> !out_valid, "result right after reset")

  // status is one of the defined codes and the count fits the table
  `IST_ASSERT(a_legal, out_valid |-> (out_status <= ST_FULL) && (out_count <= count_t'(CAPACITY)), "bad status or count")

  // full only with every slot in use and the value absent
  `IST_ASSERT(a_full, out_valid && out_status == ST_FULL |-> !out_member && out_count == count_t'(CAPACITY), "inconsistent full result")

endmodule

bind integer_set_table ist_checker u_ist_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_member (out_ch.member),
  .out_status (out_ch.status),
  .out_count  (out_ch.count)
);
